[hdl/frame_allocator_fifo_replace_assert.svh]
// assertion macros shared by the frame allocator rtl
`ifndef FRAME_ALLOCATOR_FIFO_REPLACE_ASSERT_SVH
`define FRAME_ALLOCATOR_FIFO_REPLACE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define FAFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("frame allocator check failed");

// next-cycle implication, disabled while reset is low
`define FAFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("frame allocator check failed");

`endif

[hdl/fafr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fafr_pkg
// Shared constants, mode codes and result type of the frame allocator.
// ----------------------------------------------------------------------------
package fafr_pkg;

    localparam int FRAMES_DEF = 64;

    localparam int MODE_W  = 2;
    localparam int INDEX_W = 8;
    localparam int PAGE_W  = 16;
    localparam int FNUM_W  = 7;

    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SET   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd3;

    typedef struct packed {
        logic              status;
        logic [FNUM_W-1:0] frame_number;
        logic              replaced;
        logic              page_valid;
        logic [PAGE_W-1:0] page_out;
    } t_result;

endpackage
`default_nettype wire

[hdl/fafr_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fafr_req_if / fafr_rsp_if
// Valid/ready channels for allocator requests and results.
// ----------------------------------------------------------------------------
interface fafr_req_if;
    logic                         valid;
    logic                         ready;
    logic [fafr_pkg::MODE_W-1:0]  mode;
    logic [fafr_pkg::INDEX_W-1:0] frame_index;
    logic [fafr_pkg::PAGE_W-1:0]  page_number;

    modport source (output valid, mode, frame_index, page_number, input ready);
    modport sink   (input valid, mode, frame_index, page_number, output ready);
endinterface

interface fafr_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        status;
    logic [fafr_pkg::FNUM_W-1:0] frame_number;
    logic                        replaced;
    logic                        page_valid;
    logic [fafr_pkg::PAGE_W-1:0] page_out;

    modport source (output valid, status, frame_number, replaced, page_valid, page_out,
                    input ready);
    modport sink   (input valid, status, frame_number, replaced, page_valid, page_out,
                    output ready);
endinterface
`default_nettype wire

[hdl/frame_allocator_fifo_replace.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// frame_allocator_fifo_replace
// Physical frame allocator with round-robin replacement and page mapping store.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one request per transaction (mode, frame_index, page_number);
//   o_rsp returns exactly one result per request, in order.
//   The block handles one request at a time: i_req.ready is high only while
//   the sequencer is idle. Allocation walks the used bits one frame per
//   cycle through a single compare unit; an allocation that finds a free
//   frame ends the walk there, and one that finds none falls back to
//   replacement after the last frame. Free, set and out-of-range requests
//   go from the execute state straight to done, a mapping read passes the
//   read state as well (one page RAM read port, registered). Once the
//   result is registered the sequencer is idle and takes the next request.
//   The result sits in an output register, so a new request is worked on
//   while the previous result waits; if the receiver still stalls when the
//   next result is done, the sequencer holds until the register frees up.
//   Reset clears all used and mapping-valid bits and the replacement
//   pointer; the page RAM needs no clearing since it is read only behind a
//   set mapping-valid bit.
// ----------------------------------------------------------------------------
`include "frame_allocator_fifo_replace_assert.svh"

module frame_allocator_fifo_replace #(
    parameter int FRAMES = fafr_pkg::FRAMES_DEF
) (
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    fafr_req_if.sink   i_req,
    fafr_rsp_if.source o_rsp
);

    import fafr_pkg::*;

    localparam int IDXW = $clog2(FRAMES);
    localparam logic [IDXW-1:0] LAST_IDX = IDXW'(FRAMES - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]         r_state,     n_state;
    logic [FRAMES-1:0]  r_used,      n_used;
    logic [FRAMES-1:0]  r_mvalid,    n_mvalid;
    logic [IDXW-1:0]    r_ptr,       n_ptr;
    logic               r_out_valid, n_out_valid;

    logic [MODE_W-1:0]  r_mode,      n_mode;
    logic [INDEX_W-1:0] r_idx,       n_idx;
    logic [PAGE_W-1:0]  r_page,      n_page;
    logic [IDXW-1:0]    r_scan,      n_scan;
    t_result            r_res,       n_res;
    t_result            r_out,       n_out;

    logic               w_oor;
    logic [IDXW-1:0]    w_frame;
    logic               w_ram_we;
    logic [PAGE_W-1:0]  w_ram_rdata;

    assign w_oor   = {1'b0, r_idx} >= (INDEX_W + 1)'(FRAMES);
    assign w_frame = r_idx[IDXW-1:0];
    assign w_ram_we = (r_state == S_EXEC) && (r_mode == MODE_SET) && !w_oor;

    fafr_ram #(
        .WIDTH(PAGE_W),
        .DEPTH(FRAMES)
    ) u_page_ram (
        .i_clk  (i_clk),
        .i_we   (w_ram_we),
        .i_waddr(w_frame),
        .i_wdata(r_page),
        .i_raddr(w_frame),
        .o_rdata(w_ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_mvalid    = r_mvalid;
        n_ptr       = r_ptr;
        n_out_valid = r_out_valid;
        n_mode      = r_mode;
        n_idx       = r_idx;
        n_page      = r_page;
        n_scan      = r_scan;
        n_res       = r_res;
        n_out       = r_out;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_mode  = i_req.mode;
                    n_idx   = i_req.frame_index;
                    n_page  = i_req.page_number;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_res  = '0;
                n_scan = '0;
                if (r_mode == MODE_ALLOC) begin
                    n_state = S_SCAN;
                end else if (w_oor) begin
                    n_res.status = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    unique case (r_mode)
                        MODE_FREE: begin
                            n_used[w_frame]   = 1'b0;
                            n_mvalid[w_frame] = 1'b0;
                            n_state           = S_DONE;
                        end
                        MODE_SET: begin
                            n_mvalid[w_frame] = 1'b1;
                            n_state           = S_DONE;
                        end
                        default: begin
                            // mapping read, data arrives next cycle
                            n_state = S_READ;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (!r_used[r_scan]) begin
                    n_used[r_scan]     = 1'b1;
                    n_res.frame_number = FNUM_W'(r_scan) + FNUM_W'(1);
                    n_state            = S_DONE;
                end else if (r_scan == LAST_IDX) begin
                    // every frame taken: hand out the one under the pointer
                    n_res.frame_number = FNUM_W'(r_ptr) + FNUM_W'(1);
                    n_res.replaced     = 1'b1;
                    n_ptr              = (r_ptr == LAST_IDX) ? '0 : r_ptr + IDXW'(1);
                    n_state            = S_DONE;
                end else begin
                    n_scan = r_scan + IDXW'(1);
                end
            end
            S_READ: begin
                if (r_mvalid[w_frame]) begin
                    n_res.page_valid = 1'b1;
                    n_res.page_out   = w_ram_rdata;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_mvalid    <= '0;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_mvalid    <= n_mvalid;
            r_ptr       <= n_ptr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode <= n_mode;
        r_idx  <= n_idx;
        r_page <= n_page;
        r_scan <= n_scan;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out.status;
    assign o_rsp.frame_number = r_out.frame_number;
    assign o_rsp.replaced     = r_out.replaced;
    assign o_rsp.page_valid   = r_out.page_valid;
    assign o_rsp.page_out     = r_out.page_out;

    `FAFR_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_req.valid && i_req.ready, !i_req.ready)
    `FAFR_ASSERT_NOW(a_ptr_range, i_clk, i_rst_n, 1'b1, r_ptr <= LAST_IDX)
    `FAFR_ASSERT_NOW(a_repl_clean, i_clk, i_rst_n, o_rsp.valid && o_rsp.replaced, !o_rsp.status && !o_rsp.page_valid)

endmodule
`default_nettype wire

[hdl/fafr_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fafr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fafr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire
